// ===== hw/rtl/ps2mpt_pkg.sv =====
// Package for the PS/2 mouse packet tracker.
// It holds the header bit masks, the phase type, the button codes and the register indexes.
// It has no dependencies.
package ps2mpt_pkg;

    localparam int unsigned PosWidth  = 12;
    localparam int unsigned CfgIdxW   = 2;

    localparam logic [7:0] HDR_ALWAYS_ONE = 8'h08;
    localparam logic [7:0] HDR_OVERFLOW   = 8'hC0;
    localparam logic [7:0] HDR_BTN_LEFT   = 8'h01;
    localparam logic [7:0] HDR_BTN_RIGHT  = 8'h02;
    localparam logic [7:0] HDR_BTN_MIDDLE = 8'h04;

    localparam logic [PosWidth-1:0] RESET_MAX_X = 12'd1024;
    localparam logic [PosWidth-1:0] RESET_MAX_Y = 12'd768;

    localparam logic [CfgIdxW-1:0] CFG_MAX_X = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_Y = 2'd1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        BTN_NONE   = 2'd0,
        BTN_LEFT   = 2'd1,
        BTN_RIGHT  = 2'd2,
        BTN_MIDDLE = 2'd3
    } button_t;

endpackage

// ===== hw/rtl/ps2_mouse_packet_tracker_core.sv =====
// Top level of the PS/2 mouse packet tracker.
// Assembles three-byte mouse packets and tracks a clamped pointer position.
// Depends on ps2mpt_pkg.
// A result is registered as the Y byte of its packet leaves the input register.
// Throughput: one byte per cycle; an input register feeds one step of logic and
// the result register; a result not yet taken stalls only a byte that gives one.
// Reset clears the packet phase and both positions and sets the limits to 1024 and 768.
module ps2_mouse_packet_tracker_core
    import ps2mpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [PosWidth-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 from_aux,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PosWidth-1:0]  x_position,
    output logic [PosWidth-1:0]  y_position,
    output logic [1:0]           button_code
);

    localparam int unsigned SumW = PosWidth + 2;

    logic [PosWidth-1:0] max_x_reg, max_y_reg;
    logic                s_valid_reg;
    logic                s_aux_reg;
    logic [7:0]          s_byte_reg;
    phase_t              phase_reg, phase_next;
    logic [7:0]          header_reg, header_next;
    logic [7:0]          xdelta_reg, xdelta_next;
    logic [PosWidth-1:0] pos_x_reg, pos_x_next;
    logic [PosWidth-1:0] pos_y_reg, pos_y_next;
    logic                out_valid_reg, out_valid_next;
    logic [PosWidth-1:0] x_out_reg, y_out_reg;
    logic [1:0]          btn_out_reg;

    logic                emit;
    logic                advance;
    logic signed [SumW-1:0] sum_x, sum_y;
    logic [PosWidth-1:0] new_x, new_y;
    button_t             btn;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= RESET_MAX_X;
            max_y_reg <= RESET_MAX_Y;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAX_X)
            begin
                max_x_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MAX_Y)
            begin
                max_y_reg <= cfg_data;
            end
        end
    end

    // The packet completes on an aux byte in the Y phase; overflowed packets give no item.
    assign emit    = s_valid_reg && s_aux_reg && (phase_reg == PH_Y)
                     && ((header_reg & HDR_OVERFLOW) == 8'h00);
    assign advance = s_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !s_valid_reg || advance;

    always_comb
    begin
        sum_x = $signed({2'b00, pos_x_reg})
                + $signed({{(SumW-8){xdelta_reg[7]}}, xdelta_reg});
        sum_y = $signed({2'b00, pos_y_reg})
                - $signed({{(SumW-8){s_byte_reg[7]}}, s_byte_reg});

        if (sum_x < 0)
        begin
            new_x = '0;
        end
        else if (sum_x[SumW-1:0] > {2'b00, max_x_reg})
        begin
            new_x = max_x_reg;
        end
        else
        begin
            new_x = sum_x[PosWidth-1:0];
        end

        if (sum_y < 0)
        begin
            new_y = '0;
        end
        else if (sum_y[SumW-1:0] > {2'b00, max_y_reg})
        begin
            new_y = max_y_reg;
        end
        else
        begin
            new_y = sum_y[PosWidth-1:0];
        end

        if ((header_reg & HDR_BTN_LEFT) != 8'h00)
        begin
            btn = BTN_LEFT;
        end
        else if ((header_reg & HDR_BTN_RIGHT) != 8'h00)
        begin
            btn = BTN_RIGHT;
        end
        else if ((header_reg & HDR_BTN_MIDDLE) != 8'h00)
        begin
            btn = BTN_MIDDLE;
        end
        else
        begin
            btn = BTN_NONE;
        end
    end

    // Next state of the packet assembler.
    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xdelta_next = xdelta_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        if (advance && s_aux_reg)
        begin
            case (phase_reg)
                PH_X:
                begin
                    xdelta_next = s_byte_reg;
                    phase_next  = PH_Y;
                end
                PH_Y:
                begin
                    phase_next = PH_HEADER;
                    if (emit)
                    begin
                        pos_x_next = new_x;
                        pos_y_next = new_y;
                    end
                end
                default:
                begin
                    header_next = s_byte_reg;
                    phase_next  = ((s_byte_reg & HDR_ALWAYS_ONE) != 8'h00) ? PH_X : PH_HEADER;
                end
            endcase
        end
    end

    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            phase_reg     <= PH_HEADER;
            header_reg    <= '0;
            xdelta_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s_valid_reg <= in_valid;
            end
            phase_reg     <= phase_next;
            header_reg    <= header_next;
            xdelta_reg    <= xdelta_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s_aux_reg  <= from_aux;
            s_byte_reg <= data_byte;
        end
        if (advance && emit)
        begin
            x_out_reg   <= new_x;
            y_out_reg   <= new_y;
            btn_out_reg <= btn;
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_position  = x_out_reg;
    assign y_position  = y_out_reg;
    assign button_code = btn_out_reg;

endmodule
